/* src/cbsa_pkg.sv */
// cbsa_pkg: shared types and constants for the coverage block set accumulator
// used by the top level and by its checker; no dependencies

package cbsa_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int COUNT_W     = 13;
  localparam int ADDR_BITS   = 64;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MODULE_BASE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODULE_LIMIT = 1'd1;

  // one reported basic block
  typedef struct packed {
    logic [ADDR_BITS-1:0] block_start;
    logic [ADDR_BITS-1:0] block_end;
    logic                 report_last;
  } blk_t;

  // one result transaction
  typedef struct packed {
    logic               inside_module;
    logic               already_seen;
    logic               was_inserted;
    logic               table_full;
    logic               report_new;
    logic [COUNT_W-1:0] entries_used;
  } res_t;

endpackage

/* src/coverage_block_set_accumulator.sv */
// coverage_block_set_accumulator: deduplicating table of basic blocks
// depends on cbsa_pkg
//
// Usage:
//   blk channel (blk_valid/blk_stall/blk) carries one basic block per
//   transaction; report_last marks the final block of a coverage report.
//   res channel (res_valid/res_stall/res) returns one result per block, in order.
//   cfg_we/cfg_index/cfg_data write module_base (index 0) and module_limit
//   (index 1); write only while no block is in flight.
// Timing:
//   one block at a time. The stored pairs live in one 4096 x 128 memory with
//   a registered read port, scanned one entry per cycle from entry 0.
//   A block goes from accept through the scan to the output register; the scan
//   stops on the first match and is skipped with an empty table. A new block
//   is accepted only once the current result has been loaded.
// Reset:
//   synchronous rst clears entry count, report novelty, state and res_valid;
//   base resets to zero and limit to all ones. Memory contents are not cleared,
//   entries at or beyond the count never take part in a compare.
// Stall:
//   the result sits in an output register; a new block is accepted while it
//   waits, but the next result is held back until res_stall drops.

module coverage_block_set_accumulator (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           blk_valid,
  output logic                           blk_stall,
  input  cbsa_pkg::blk_t                 blk,
  output logic                           res_valid,
  input  logic                           res_stall,
  output cbsa_pkg::res_t                 res,
  input  logic                           cfg_we,
  input  logic [cbsa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cbsa_pkg::ADDR_BITS-1:0] cfg_data
);
  import cbsa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t               state;
  logic [ADDR_BITS-1:0] module_base;
  logic [ADDR_BITS-1:0] module_limit;
  logic [COUNT_W-1:0]   entry_count;
  logic                 novelty_seen;

  // latched block under test
  blk_t                 cur;
  logic                 cur_inside;
  logic                 cur_seen;

  // scan control
  logic [COUNT_W-1:0]   scan_addr;
  logic                 issue_active;
  logic                 rd_valid;
  logic                 rd_last;

  // pair memory: start in upper half, end in lower half
  logic [2*ADDR_BITS-1:0] pair_mem [TABLE_DEPTH];
  logic [2*ADDR_BITS-1:0] rd_data;
  logic                   mem_we;
  logic [ADDR_W-1:0]      wr_addr;

  logic                 out_free;
  logic                 fresh;
  logic                 has_room;
  logic                 nov_next;
  logic                 rd_match;
  logic [COUNT_W-1:0]   count_next;

  assign blk_stall = (state != S_IDLE);
  assign out_free  = !res_valid || !res_stall;
  assign fresh     = cur_inside && !cur_seen;
  assign has_room  = (entry_count < COUNT_W'(TABLE_DEPTH));
  assign nov_next  = novelty_seen || fresh;
  assign rd_match  = rd_valid && (rd_data == {cur.block_start, cur.block_end});
  assign mem_we    = (state == S_DONE) && out_free && fresh && has_room;
  assign wr_addr   = entry_count[ADDR_W-1:0];
  assign count_next = (fresh && has_room) ? entry_count + COUNT_W'(1) : entry_count;

  // pair memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      pair_mem[wr_addr] <= {cur.block_start, cur.block_end};
    end
    rd_data <= pair_mem[scan_addr[ADDR_W-1:0]];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      module_base  <= '0;
      module_limit <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODULE_BASE:  module_base  <= cfg_data;
        REG_MODULE_LIMIT: module_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer, scan and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      entry_count  <= '0;
      novelty_seen <= 1'b0;
      res_valid    <= 1'b0;
      issue_active <= 1'b0;
      rd_valid     <= 1'b0;
      rd_last      <= 1'b0;
      scan_addr    <= '0;
    end else begin
      // a taken result empties the output register unless a new one loads
      if (res_valid && !res_stall && state != S_DONE) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          rd_valid     <= 1'b0;
          scan_addr    <= '0;
          issue_active <= blk_valid && (entry_count != '0);
          if (blk_valid) begin
            cur        <= blk;
            cur_inside <= (blk.block_start >= module_base) &&
                          (blk.block_end <= module_limit);
            cur_seen   <= 1'b0;
            if (entry_count == '0) begin
              state <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // issue side: one read per cycle up to the last stored entry
          rd_valid     <= issue_active;
          rd_last      <= (scan_addr == entry_count - COUNT_W'(1));
          issue_active <= issue_active && !rd_match &&
                          (scan_addr != entry_count - COUNT_W'(1));
          if (issue_active) begin
            scan_addr <= scan_addr + COUNT_W'(1);
          end
          // compare side: stop on first match or after the last entry
          if (rd_match) begin
            cur_seen <= 1'b1;
            state    <= S_DONE;
          end else if (rd_valid && rd_last) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          rd_valid <= 1'b0;
          if (out_free) begin
            entry_count            <= count_next;
            novelty_seen           <= cur.report_last ? 1'b0 : nov_next;
            res_valid              <= 1'b1;
            res.inside_module      <= cur_inside;
            res.already_seen       <= cur_seen;
            res.was_inserted       <= fresh && has_room;
            res.table_full         <= fresh && !has_room;
            res.report_new         <= cur.report_last && nov_next;
            res.entries_used       <= count_next;
            state                  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* src/cbsa_check.sv */
// cbsa_check: port-level assertions for coverage_block_set_accumulator
// depends on cbsa_pkg; bound to the top level at the end of this file

module cbsa_check (
  input logic           clk,
  input logic           rst,
  input logic           blk_valid,
  input logic           blk_stall,
  input logic           res_valid,
  input logic           res_stall,
  input cbsa_pkg::res_t res
);
  import cbsa_pkg::*;

  // a stalled result stays offered
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid)
    else $error("result dropped while stalled");

  // one block at a time: input closes right after a transaction
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    blk_valid && !blk_stall |=> blk_stall)
    else $error("second block accepted while one is in flight");

  // an insert needs an in-module block that was not stored
  a_insert_fresh: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.was_inserted |-> res.inside_module && !res.already_seen)
    else $error("insert of a block that is not new");

  // dropping only happens at a full table, never together with an insert
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.table_full |->
      !res.was_inserted && res.entries_used == COUNT_W'(TABLE_DEPTH))
    else $error("full flag without a full table");

  // the count never passes the table depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.entries_used <= COUNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

endmodule

bind coverage_block_set_accumulator cbsa_check u_cbsa_check (
  .clk       (clk),
  .rst       (rst),
  .blk_valid (blk_valid),
  .blk_stall (blk_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);
